// ----- design/pocl_pkg.sv -----
// package for the polyline off-screen point culler
// region codes, configuration register indexes and widths; no dependencies
package pocl_pkg;

    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SURFACE_WIDTH_RST  = 15'd640;
    localparam logic [CFG_DATA_W-1:0] SURFACE_HEIGHT_RST = 15'd480;

    typedef enum logic [3:0] {
        REG_INSIDE       = 4'd0,
        REG_LEFT         = 4'd1,
        REG_TOP_LEFT     = 4'd2,
        REG_TOP          = 4'd3,
        REG_TOP_RIGHT    = 4'd4,
        REG_RIGHT        = 4'd5,
        REG_BOTTOM_RIGHT = 4'd6,
        REG_BOTTOM       = 4'd7,
        REG_BOTTOM_LEFT  = 4'd8
    } t_region;

    function automatic t_region classify(input logic xl, input logic xr,
                                         input logic yt, input logic yb);
        t_region r;
        if (xl) begin
            r = yt ? REG_TOP_LEFT : (yb ? REG_BOTTOM_LEFT : REG_LEFT);
        end else if (xr) begin
            r = yt ? REG_TOP_RIGHT : (yb ? REG_BOTTOM_RIGHT : REG_RIGHT);
        end else if (yt) begin
            r = REG_TOP;
        end else if (yb) begin
            r = REG_BOTTOM;
        end else begin
            r = REG_INSIDE;
        end
        return r;
    endfunction

endpackage

// ----- design/pocl_front.sv -----
// front end: takes vertices, classifies them and keeps the line history
// pushes one emit command per kept vertex into the queue; uses pocl_pkg
module pocl_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic                                i_line_start,
    input  logic [pocl_pkg::CFG_DATA_W-1:0]     i_surface_width,
    input  logic [pocl_pkg::CFG_DATA_W-1:0]     i_surface_height,
    input  logic                                i_q_ready,
    output logic                                o_q_push,
    output logic [4*COORD_BITS:0]               o_q_data
);

    localparam int CMP_W = (COORD_BITS > 16) ? COORD_BITS : 16;

    logic signed [COORD_BITS-1:0] r_prev_x, n_prev_x;
    logic signed [COORD_BITS-1:0] r_prev_y, n_prev_y;
    logic                         r_prev_valid, n_prev_valid;
    pocl_pkg::t_region            r_blocked, n_blocked;
    logic                         r_omit, n_omit;

    logic signed [CMP_W-1:0] x_ext, y_ext, w_ext, h_ext;
    logic                    accept, pv, omit_eff, dup, keep;
    pocl_pkg::t_region       blk_eff, region;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    assign x_ext = CMP_W'(i_point_x);
    assign y_ext = CMP_W'(i_point_y);
    assign w_ext = CMP_W'({1'b0, i_surface_width});
    assign h_ext = CMP_W'({1'b0, i_surface_height});

    assign pv       = r_prev_valid && !i_line_start;
    assign blk_eff  = i_line_start ? pocl_pkg::REG_INSIDE : r_blocked;
    assign omit_eff = r_omit && !i_line_start;
    assign dup      = pv && (i_point_x == r_prev_x) && (i_point_y == r_prev_y);
    assign region   = pocl_pkg::classify(x_ext < 0, x_ext >= w_ext,
                                         y_ext < 0, y_ext >= h_ext);
    assign keep     = (blk_eff == pocl_pkg::REG_INSIDE) || (region != blk_eff);

    assign o_q_push = accept && !dup && keep;
    assign o_q_data = {omit_eff, r_prev_x, r_prev_y, i_point_x, i_point_y};

    always_comb begin
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_prev_valid = r_prev_valid;
        n_blocked    = r_blocked;
        n_omit       = r_omit;
        if (accept && !dup) begin
            n_prev_x     = i_point_x;
            n_prev_y     = i_point_y;
            n_prev_valid = 1'b1;
            n_blocked    = region;
            n_omit       = !keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_valid <= 1'b0;
            r_blocked    <= pocl_pkg::REG_INSIDE;
            r_omit       <= 1'b0;
        end else begin
            r_prev_x     <= n_prev_x;
            r_prev_y     <= n_prev_y;
            r_prev_valid <= n_prev_valid;
            r_blocked    <= n_blocked;
            r_omit       <= n_omit;
        end
    end

endmodule

// ----- design/pocl_queue.sv -----
// two-entry command queue between front and back end
// generic width, no package dependency
module pocl_queue #(
    parameter int WIDTH = 65
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- design/pocl_back.sv -----
// back end: expands queued commands into one or two output transactions
// registered output stage; no package dependency
module pocl_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic [4*COORD_BITS:0]        i_q_data,
    output logic                         o_q_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic                         o_run_last
);

    logic                         two;
    logic signed [COORD_BITS-1:0] px, py, cx, cy;

    logic                         r_valid, n_valid;
    logic                         r_phase, n_phase;
    logic signed [COORD_BITS-1:0] r_x, n_x, r_y, n_y;
    logic                         r_last, n_last;
    logic                         load;

    assign {two, px, py, cx, cy} = i_q_data;
    assign load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        n_x     = r_x;
        n_y     = r_y;
        n_last  = r_last;
        o_q_pop = 1'b0;
        if (load) begin
            n_valid = 1'b0;
            if (r_phase) begin
                n_valid = 1'b1;
                n_x     = cx;
                n_y     = cy;
                n_last  = 1'b1;
                n_phase = 1'b0;
                o_q_pop = 1'b1;
            end else if (i_q_valid) begin
                n_valid = 1'b1;
                if (two) begin
                    n_x     = px;
                    n_y     = py;
                    n_last  = 1'b0;
                    n_phase = 1'b1;
                end else begin
                    n_x     = cx;
                    n_y     = cy;
                    n_last  = 1'b1;
                    o_q_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_last <= n_last;
    end

    assign o_valid    = r_valid;
    assign o_out_x    = r_x;
    assign o_out_y    = r_y;
    assign o_run_last = r_last;

endmodule

// ----- design/polyline_offscreen_point_culler.sv -----
// top level of the polyline off-screen point culler
// holds the surface size registers; uses pocl_pkg, pocl_front, pocl_queue, pocl_back
//
// Vertices enter one per cycle while the queue has room and are classed
// against the surface in the same cycle; kept vertices wait in a two-entry
// queue for the output stage. A vertex that emits one result takes one output
// transaction, one that emits the pending omitted vertex plus itself takes two,
// and the single registered output stage limits the sustained rate. A vertex
// passes through the queue and then the output register before it appears.
// Dropped vertices take no output transaction.
module polyline_offscreen_point_culler #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [pocl_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [pocl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic                                i_line_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_BITS-1:0]        o_out_x,
    output logic signed [COORD_BITS-1:0]        o_out_y,
    output logic                                o_run_last
);

    localparam int Q_W = 4 * COORD_BITS + 1;

    logic [pocl_pkg::CFG_DATA_W-1:0] r_surface_width, n_surface_width;
    logic [pocl_pkg::CFG_DATA_W-1:0] r_surface_height, n_surface_height;

    logic           q_push, q_ready, q_pop, q_valid;
    logic [Q_W-1:0] q_wdata, q_rdata;

    always_comb begin
        n_surface_width  = r_surface_width;
        n_surface_height = r_surface_height;
        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                pocl_pkg::CFG_SURFACE_WIDTH:  n_surface_width  = i_cfg_wdata;
                pocl_pkg::CFG_SURFACE_HEIGHT: n_surface_height = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_width  <= pocl_pkg::SURFACE_WIDTH_RST;
            r_surface_height <= pocl_pkg::SURFACE_HEIGHT_RST;
        end else begin
            r_surface_width  <= n_surface_width;
            r_surface_height <= n_surface_height;
        end
    end

    pocl_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_line_start     (i_line_start),
        .i_surface_width  (r_surface_width),
        .i_surface_height (r_surface_height),
        .i_q_ready        (q_ready),
        .o_q_push         (q_push),
        .o_q_data         (q_wdata)
    );

    pocl_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    pocl_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_run_last (o_run_last)
    );

endmodule

// ----- tb/pocl_checker.sv -----
// result checker for the polyline off-screen point culler testbench
// watches both channels and the register port, predicts emitted vertices; uses pocl_pkg
module pocl_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pocl_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [pocl_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [COORD_BITS-1:0]       i_point_x,
    input  logic signed [COORD_BITS-1:0]       i_point_y,
    input  logic                               i_line_start,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [COORD_BITS-1:0]       i_out_x,
    input  logic signed [COORD_BITS-1:0]       i_out_y,
    input  logic                               i_run_last,
    output int                                 o_mismatches,
    output int                                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } t_emitted;

    t_emitted                          emitted_q[$];
    logic [pocl_pkg::CFG_DATA_W-1:0]   surf_w;
    logic [pocl_pkg::CFG_DATA_W-1:0]   surf_h;
    logic signed [COORD_BITS-1:0]      last_x;
    logic signed [COORD_BITS-1:0]      last_y;
    logic                              have_last;
    pocl_pkg::t_region                 blocked;
    logic                              omit_pending;
    int                                mismatches;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        mismatches    = 0;
    end

    function automatic pocl_pkg::t_region region_of(
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y);
        int                xi;
        int                yi;
        pocl_pkg::t_region r;
        xi = int'(x);
        yi = int'(y);
        if (yi < 0) begin
            r = (xi < 0) ? pocl_pkg::REG_TOP_LEFT :
                ((xi >= int'(surf_w)) ? pocl_pkg::REG_TOP_RIGHT : pocl_pkg::REG_TOP);
        end else if (yi >= int'(surf_h)) begin
            r = (xi < 0) ? pocl_pkg::REG_BOTTOM_LEFT :
                ((xi >= int'(surf_w)) ? pocl_pkg::REG_BOTTOM_RIGHT : pocl_pkg::REG_BOTTOM);
        end else begin
            r = (xi < 0) ? pocl_pkg::REG_LEFT :
                ((xi >= int'(surf_w)) ? pocl_pkg::REG_RIGHT : pocl_pkg::REG_INSIDE);
        end
        return r;
    endfunction

    task automatic cull_vertex(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y,
                               input logic start);
        pocl_pkg::t_region r;
        if (start) begin
            last_x       = '0;
            last_y       = '0;
            have_last    = 1'b0;
            blocked      = pocl_pkg::REG_INSIDE;
            omit_pending = 1'b0;
        end
        if (have_last && x == last_x && y == last_y) begin
            return;
        end
        r = region_of(x, y);
        if (blocked == pocl_pkg::REG_INSIDE || r != blocked) begin
            if (omit_pending) begin
                emitted_q.push_back('{last_x, last_y, 1'b0});
            end
            emitted_q.push_back('{x, y, 1'b1});
            omit_pending = 1'b0;
        end else begin
            omit_pending = 1'b1;
        end
        last_x    = x;
        last_y    = y;
        have_last = 1'b1;
        blocked   = r;
    endtask

    task automatic check_result();
        t_emitted want;
        if (emitted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected transaction: x=%0d y=%0d last=%0d",
                         i_out_x, i_out_y, i_run_last);
            end
            return;
        end
        want = emitted_q.pop_front();
        if (want.x !== i_out_x || want.y !== i_out_y || want.last !== i_run_last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                         want.x, want.y, want.last, i_out_x, i_out_y, i_run_last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            emitted_q.delete();
            surf_w       = pocl_pkg::SURFACE_WIDTH_RST;
            surf_h       = pocl_pkg::SURFACE_HEIGHT_RST;
            last_x       = '0;
            last_y       = '0;
            have_last    = 1'b0;
            blocked      = pocl_pkg::REG_INSIDE;
            omit_pending = 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    pocl_pkg::CFG_SURFACE_WIDTH: begin
                        surf_w = i_cfg_wdata;
                    end
                    pocl_pkg::CFG_SURFACE_HEIGHT: begin
                        surf_h = i_cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                cull_vertex(i_point_x, i_point_y, i_line_start);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= emitted_q.size();
    end

endmodule

// ----- tb/tb_polyline_offscreen_point_culler.sv -----
// testbench top for the polyline off-screen point culler
// drives directed and random polylines, register writes and handshake gaps;
// uses pocl_pkg, pocl_checker and the design under test
module tb_polyline_offscreen_point_culler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB         = 16;
    localparam int QUIET_MAX  = 5000;
    localparam int PHASE_ITEMS = 450;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_wr_en;
    logic [pocl_pkg::CFG_IDX_W-1:0]      i_cfg_addr;
    logic [pocl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata;
    logic                                i_valid;
    logic                                o_ready;
    logic signed [CB-1:0]                i_point_x;
    logic signed [CB-1:0]                i_point_y;
    logic                                i_line_start;
    logic                                o_valid;
    logic                                i_ready;
    logic signed [CB-1:0]                o_out_x;
    logic signed [CB-1:0]                o_out_y;
    logic                                o_run_last;

    int                           mismatches;
    int                           outstanding;
    int                           idle_pct;
    int                           stall_pct;
    int                           quiet_cycles;
    int                           cur_w;
    int                           cur_h;
    logic signed [CB-1:0]         sent_x;
    logic signed [CB-1:0]         sent_y;

    polyline_offscreen_point_culler #(.COORD_BITS(CB)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_line_start (i_line_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_run_last   (o_run_last)
    );

    pocl_checker #(.COORD_BITS(CB)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_line_start  (i_line_start),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_run_last    (o_run_last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_vertex(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                               input logic start);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_point_x    <= x;
        i_point_y    <= y;
        i_line_start <= start;
        sent_x       = x;
        sent_y       = y;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    // sender holds off until every expected vertex has come out, then lets the pipe drain
    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_surface(input int w, input int h);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= pocl_pkg::CFG_SURFACE_WIDTH;
        i_cfg_wdata <= w[pocl_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_addr  <= pocl_pkg::CFG_SURFACE_HEIGHT;
        i_cfg_wdata <= h[pocl_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    function automatic logic signed [CB-1:0] pick_coord(input int bound,
                                                        input logic signed [CB-1:0] prior);
        logic signed [CB-1:0] c;
        case ($urandom_range(9))
            0, 1: begin
                c = CB'($urandom);
            end
            2, 3, 4: begin
                c = CB'(int'(prior) + int'($urandom_range(6)) - 3);
            end
            5, 6: begin
                c = CB'((($urandom_range(1) != 0) ? bound : 0) + int'($urandom_range(4)) - 2);
            end
            default: begin
                c = CB'(int'($urandom_range(2 * bound + 2)) - bound / 2 - 1);
            end
        endcase
        return c;
    endfunction

    task automatic draw_polyline(input int len, inout int count);
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 start;
        for (int k = 0; k < len; k++) begin
            start = (k == 0) || ($urandom_range(29) == 0);
            if (k > 0 && $urandom_range(9) == 0) begin
                x = sent_x;
                y = sent_y;
            end else begin
                x = pick_coord(cur_w, sent_x);
                y = pick_coord(cur_h, sent_y);
            end
            send_vertex(x, y, start);
            count++;
        end
    endtask

    task automatic pick_surface();
        case ($urandom_range(5))
            0: set_surface($urandom_range(1, 64), $urandom_range(1, 64));
            1: set_surface(int'(pocl_pkg::SURFACE_WIDTH_RST),
                           int'(pocl_pkg::SURFACE_HEIGHT_RST));
            2: set_surface($urandom_range(1, 32767), $urandom_range(1, 32767));
            3: set_surface(0, $urandom_range(1, 32));
            4: set_surface($urandom_range(1, 32), 32767);
            default: set_surface($urandom_range(1, 16), $urandom_range(1, 16));
        endcase
    endtask

    initial begin
        int count;
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_addr   = pocl_pkg::CFG_SURFACE_WIDTH;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_point_x    = '0;
        i_point_y    = '0;
        i_line_start = 1'b0;
        i_ready      = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        cur_w        = int'(pocl_pkg::SURFACE_WIDTH_RST);
        cur_h        = int'(pocl_pkg::SURFACE_HEIGHT_RST);
        sent_x       = '0;
        sent_y       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset surface: duplicates, omissions, every region, field extremes
        send_vertex(16'sd10, 16'sd10, 1'b1);
        send_vertex(16'sd10, 16'sd10, 1'b0);
        send_vertex(-16'sd5, 16'sd10, 1'b0);
        send_vertex(-16'sd100, 16'sd200, 1'b0);
        send_vertex(-16'sd100, 16'sd200, 1'b0);
        send_vertex(-16'sd200, 16'sd300, 1'b0);
        send_vertex(16'sd50, 16'sd50, 1'b0);
        send_vertex(-16'sd1, -16'sd1, 1'b0);
        send_vertex(16'sd5, -16'sd1, 1'b0);
        send_vertex(16'sd640, -16'sd1, 1'b0);
        send_vertex(16'sd640, 16'sd5, 1'b0);
        send_vertex(16'sd640, 16'sd480, 1'b0);
        send_vertex(16'sd5, 16'sd480, 1'b0);
        send_vertex(-16'sd1, 16'sd480, 1'b0);
        send_vertex(16'sd639, 16'sd479, 1'b0);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd700, 16'sd10, 1'b1);
        send_vertex(16'sd800, 16'sd20, 1'b0);
        send_vertex(16'sd800, 16'sd20, 1'b1);
        drain_pipe();

        // empty surface: nothing visible
        set_surface(0, 0);
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(16'sd5, 16'sd5, 1'b0);
        send_vertex(-16'sd1, -16'sd1, 1'b0);
        send_vertex(-16'sd1, 16'sd3, 1'b0);
        drain_pipe();

        set_surface(32767, 32767);
        send_vertex(16'sd32766, 16'sd32766, 1'b1);
        send_vertex(16'sd32767, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd32767, 1'b0);
        drain_pipe();

        set_surface(1, 1);
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(16'sd1, 16'sd0, 1'b0);
        send_vertex(16'sd1, 16'sd1, 1'b0);
        drain_pipe();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 87; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 87; end
                default: begin idle_pct = 34; stall_pct <= 34; end
            endcase
            pick_surface();
            count = 0;
            while (count < PHASE_ITEMS) begin
                if (count >= PHASE_ITEMS / 2 && count < PHASE_ITEMS / 2 + 20) begin
                    drain_pipe();
                    pick_surface();
                    count = PHASE_ITEMS / 2 + 20;
                end
                if ($urandom_range(19) == 0) begin
                    draw_polyline($urandom_range(1, 3), count);
                end else begin
                    draw_polyline($urandom_range(2, 24), count);
                end
            end
            drain_pipe();
        end

        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pocl_pkg.sv
design/pocl_front.sv
design/pocl_queue.sv
design/pocl_back.sv
design/polyline_offscreen_point_culler.sv
tb/pocl_checker.sv
tb/tb_polyline_offscreen_point_culler.sv
